// File: rtl/dft_pkg.sv
// Package with shared types and constants of the deduplication fingerprint table.
package dft_pkg;
    localparam int BUCKETS = 1024;
    localparam int WAYS = 4;
    localparam int REFCOUNT_BITS = 32;
    localparam int BKT_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FP_BITS = 256;
    localparam int KEY_BITS = 33;

    typedef enum logic [1:0] {
        OUT_UNIQUE = 2'd0,
        OUT_DUP    = 2'd1,
        OUT_FULL   = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_state;

    // One queued word from the front part to the back part.
    typedef struct packed {
        logic [BKT_BITS-1:0] bucket;
        logic [FP_BITS-1:0]  fp;
    } t_req;
endpackage

// File: rtl/dft_front.sv
// Front part: takes input words, reduces the key to a bucket and queues requests.
module dft_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [32:0]          i_bucket_key,
    input  logic [63:0]          i_fingerprint_w0,
    input  logic [63:0]          i_fingerprint_w1,
    input  logic [63:0]          i_fingerprint_w2,
    input  logic [63:0]          i_fingerprint_w3,
    output logic                 o_req_valid,
    output dft_pkg::t_req        o_req,
    input  logic                 i_req_take
);
    // Two-entry queue.
    dft_pkg::t_req r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          n_wp, n_rp;
    logic [1:0]    n_cnt;
    logic          push, pop;
    dft_pkg::t_req in_req;

    // BUCKETS is a power of two, so the modulo is the low key bits.
    assign in_req.bucket = i_bucket_key[dft_pkg::BKT_BITS-1:0];
    assign in_req.fp = {i_fingerprint_w3, i_fingerprint_w2, i_fingerprint_w1,
                        i_fingerprint_w0};

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign pop = o_req_valid && i_req_take;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req = r_q[r_rp];

    always_comb begin
        n_wp = push ? ~r_wp : r_wp;
        n_rp = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_req;
        end
    end
endmodule

// File: rtl/dft_back.sv
// Back part: bucket read, way compare, update and result register.
module dft_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  dft_pkg::t_req i_req,
    output logic          o_req_take,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_outcome,
    output logic [31:0]   o_reference_count,
    output logic [1:0]    o_way_used
);
    localparam int ROW_BITS = dft_pkg::WAYS * (dft_pkg::FP_BITS + dft_pkg::REFCOUNT_BITS);
    localparam int ENT_BITS = dft_pkg::FP_BITS + dft_pkg::REFCOUNT_BITS;
    localparam logic [dft_pkg::REFCOUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [dft_pkg::REFCOUNT_BITS-1:0] CNT_ONE =
        {{(dft_pkg::REFCOUNT_BITS-1){1'b0}}, 1'b1};
    localparam logic [dft_pkg::BKT_BITS:0] CLR_ONE = {{dft_pkg::BKT_BITS{1'b0}}, 1'b1};

    // One row per bucket holds all ways; valid bits live in a second row memory.
    logic [ROW_BITS-1:0]      r_mem [dft_pkg::BUCKETS];
    logic [dft_pkg::WAYS-1:0] r_vmem [dft_pkg::BUCKETS];
    logic [ROW_BITS-1:0]      r_row;
    logic [dft_pkg::WAYS-1:0] r_vrow;

    // Clearing pass over valid rows after reset.
    logic [dft_pkg::BKT_BITS:0] r_clr;
    logic                       clearing;

    dft_pkg::t_state r_state, n_state;
    dft_pkg::t_req   r_req;

    logic                           r_ovalid;
    logic [1:0]                     r_out;
    logic [31:0]                    r_cnt_out;
    logic [1:0]                     r_way_out;

    logic                           hit, has_free;
    logic [dft_pkg::WAY_BITS-1:0]   hit_way, free_way;
    logic [dft_pkg::REFCOUNT_BITS-1:0] hit_cnt, new_cnt;
    logic [ROW_BITS-1:0]            wr_row;
    logic [dft_pkg::WAYS-1:0]       wr_vrow;
    logic                           do_wr;
    logic                           out_free;

    assign clearing = !r_clr[dft_pkg::BKT_BITS];
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dft_pkg::ST_IDLE: if (i_req_valid && !clearing) n_state = dft_pkg::ST_READ;
            dft_pkg::ST_READ: n_state = dft_pkg::ST_DONE;
            dft_pkg::ST_DONE: if (out_free) n_state = dft_pkg::ST_IDLE;
            default: n_state = dft_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_take = (r_state == dft_pkg::ST_IDLE) && !clearing;
        do_wr = (r_state == dft_pkg::ST_DONE) && out_free;
    end

    // Way compare over the registered row.
    always_comb begin
        hit = 1'b0;
        has_free = 1'b0;
        hit_way = '0;
        free_way = '0;
        hit_cnt = '0;
        for (int w = dft_pkg::WAYS - 1; w >= 0; w--) begin
            if (!r_vrow[w]) begin
                has_free = 1'b1;
                free_way = w[dft_pkg::WAY_BITS-1:0];
            end else if (r_row[w*ENT_BITS +: dft_pkg::FP_BITS] == r_req.fp) begin
                hit = 1'b1;
                hit_way = w[dft_pkg::WAY_BITS-1:0];
                hit_cnt = r_row[w*ENT_BITS + dft_pkg::FP_BITS +: dft_pkg::REFCOUNT_BITS];
            end
        end
        new_cnt = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + CNT_ONE;
        wr_row = r_row;
        wr_vrow = r_vrow;
        if (hit) begin
            wr_row[hit_way*ENT_BITS + dft_pkg::FP_BITS +: dft_pkg::REFCOUNT_BITS] = new_cnt;
        end else if (has_free) begin
            wr_row[free_way*ENT_BITS +: ENT_BITS] = {{dft_pkg::REFCOUNT_BITS{1'b0}}, r_req.fp};
            wr_vrow[free_way] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dft_pkg::ST_IDLE;
            r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr <= r_clr + CLR_ONE;
            end
            if (do_wr) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_take && i_req_valid) begin
            r_req <= i_req;
        end
        if (r_state == dft_pkg::ST_IDLE) begin
            r_row <= r_mem[i_req.bucket];
            r_vrow <= r_vmem[i_req.bucket];
        end
        if (clearing) begin
            r_vmem[r_clr[dft_pkg::BKT_BITS-1:0]] <= '0;
        end else if (do_wr) begin
            r_vmem[r_req.bucket] <= wr_vrow;
        end
        if (do_wr && (hit || has_free)) begin
            r_mem[r_req.bucket] <= wr_row;
        end
        if (do_wr) begin
            if (hit) begin
                r_out <= dft_pkg::OUT_DUP;
                r_cnt_out <= 32'(new_cnt);
                r_way_out <= 2'(hit_way);
            end else if (has_free) begin
                r_out <= dft_pkg::OUT_UNIQUE;
                r_cnt_out <= '0;
                r_way_out <= 2'(free_way);
            end else begin
                r_out <= dft_pkg::OUT_FULL;
                r_cnt_out <= '0;
                r_way_out <= '0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_outcome = r_out;
    assign o_reference_count = r_cnt_out;
    assign o_way_used = r_way_out;
endmodule

// File: rtl/dedup_fingerprint_table_unit.sv
// Top level of the deduplication fingerprint table.
// Each input word carries a bucket key and a 256-bit fingerprint; the low ten key
// bits pick one of 1024 buckets of four ways. A match raises that entry's saturating
// reference count and reports a duplicate, otherwise the fingerprint goes into the
// lowest free way with count zero, and a full bucket is reported and dropped. Every
// input word gives exactly one result word. A two-word queue lets input words be
// taken while the back part works. The back part handles one word at a time, in the
// steps row read, compare and write-back with result register, and takes no new
// word before the last one's result is registered. After reset a clearing pass over
// all 1024 buckets clears the valid bits, during which words are queued but not
// processed.
module dedup_fingerprint_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [32:0] i_bucket_key,
    input  logic [63:0] i_fingerprint_w0,
    input  logic [63:0] i_fingerprint_w1,
    input  logic [63:0] i_fingerprint_w2,
    input  logic [63:0] i_fingerprint_w3,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_outcome,
    output logic [31:0] o_reference_count,
    output logic [1:0]  o_way_used
);
    logic          req_valid, req_take;
    dft_pkg::t_req req;

    dft_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_bucket_key(i_bucket_key), .i_fingerprint_w0(i_fingerprint_w0),
        .i_fingerprint_w1(i_fingerprint_w1), .i_fingerprint_w2(i_fingerprint_w2),
        .i_fingerprint_w3(i_fingerprint_w3), .o_req_valid(req_valid), .o_req(req),
        .i_req_take(req_take)
    );

    dft_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(req_valid), .i_req(req),
        .o_req_take(req_take), .o_valid(o_valid), .i_stall(i_stall),
        .o_outcome(o_outcome), .o_reference_count(o_reference_count),
        .o_way_used(o_way_used)
    );
endmodule

// File: rtl/dft_checker.sv
// Port checker for the deduplication fingerprint table.
module dft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_outcome,
    input logic [31:0] o_reference_count,
    input logic [1:0]  o_way_used
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_outcome)) else $error("result dropped");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_outcome != 2'd3) else $error("bad outcome");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outcome == dft_pkg::OUT_FULL |-> o_reference_count == 0 && o_way_used == 0)
        else $error("full result not zero");
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outcome == dft_pkg::OUT_UNIQUE |-> o_reference_count == 0)
        else $error("new entry count not zero");
endmodule

bind dedup_fingerprint_table_unit dft_checker u_chk (.*);
